### hw/rtl/nps_pkg.sv
// Shared types and constants for the non-overlapping pattern search unit.
`timescale 1ns / 1ps

package nps_pkg;

  localparam int MAX_PATTERN_DEF   = 16;
  localparam int POSITION_BITS_DEF = 32;
  localparam int PATTERN_BYTES     = 16;
  localparam int START_W           = 32;
  localparam int CFG_DATA_W        = 64;
  localparam int CFG_IDX_W         = 2;
  localparam int LEN_REG_W         = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW    = 2'd0,
    CFG_PATTERN_HIGH   = 2'd1,
    CFG_PATTERN_LENGTH = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] pattern_low;
    logic [CFG_DATA_W-1:0] pattern_high;
    logic [LEN_REG_W-1:0]  pattern_length;
  } cfg_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_req_t;

  typedef struct packed {
    logic               match_found;
    logic [START_W-1:0] match_start;
    logic               last_result;
  } out_res_t;

endpackage

### hw/rtl/nps_cfg_regs.sv
// Configuration register file: pattern bytes and pattern length.
`timescale 1ns / 1ps

module nps_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [nps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [nps_pkg::CFG_DATA_W-1:0]      cfg_data,
  output nps_pkg::cfg_t                       cfg
);

  nps_pkg::cfg_t cfg_r;
  nps_pkg::cfg_t cfg_nxt;

  // no write is taken while reset is held
  assign cfg_ready = rst_n;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        nps_pkg::CFG_PATTERN_LOW: begin
          cfg_nxt.pattern_low = cfg_data;
        end
        nps_pkg::CFG_PATTERN_HIGH: begin
          cfg_nxt.pattern_high = cfg_data;
        end
        nps_pkg::CFG_PATTERN_LENGTH: begin
          cfg_nxt.pattern_length = cfg_data[nps_pkg::LEN_REG_W-1:0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_low    <= '0;
      cfg_r.pattern_high   <= '0;
      cfg_r.pattern_length <= nps_pkg::LEN_REG_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### hw/rtl/nps_match_core.sv
// Byte window, position and match-spacing state with the parallel pattern compare.
`timescale 1ns / 1ps

module nps_match_core #(
  parameter int MAX_PATTERN   = nps_pkg::MAX_PATTERN_DEF,
  parameter int POSITION_BITS = nps_pkg::POSITION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  nps_pkg::in_req_t   req,
  input  nps_pkg::cfg_t      cfg,
  output nps_pkg::out_res_t  res
);

  localparam int CNT_W   = $clog2(MAX_PATTERN + 1);
  localparam int WIN_W   = $clog2(MAX_PATTERN);
  localparam int LEN_W   = nps_pkg::LEN_REG_W;
  localparam int START_W = nps_pkg::START_W;

  logic [7:0]               win_r   [MAX_PATTERN];
  logic [7:0]               win_nxt [MAX_PATTERN];
  logic [POSITION_BITS-1:0] pos_r;
  logic [POSITION_BITS-1:0] pos_nxt;
  logic [CNT_W-1:0]         bsm_r;
  logic [CNT_W-1:0]         bsm_nxt;
  logic [CNT_W-1:0]         bsm_inc;
  logic [CNT_W-1:0]         len_eff;
  logic [CNT_W-1:0]         diff;
  logic [2*nps_pkg::CFG_DATA_W-1:0] pat_bytes;
  logic                     all_eq;
  logic                     found;
  logic [POSITION_BITS-1:0] start_pos;

  // clamp length to 1..MAX_PATTERN
  always_comb begin
    if (cfg.pattern_length == '0) begin
      len_eff = CNT_W'(1);
    end else if (cfg.pattern_length > LEN_W'(MAX_PATTERN)) begin
      len_eff = CNT_W'(MAX_PATTERN);
    end else begin
      len_eff = CNT_W'(cfg.pattern_length);
    end
  end

  always_comb begin
    win_nxt[0] = req.text_byte;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      win_nxt[i] = win_r[i-1];
    end
  end

  assign pat_bytes = {cfg.pattern_high, cfg.pattern_low};

  // pattern byte k lines up with window entry len-1-k
  always_comb begin
    all_eq = 1'b1;
    diff   = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      diff = len_eff - CNT_W'(1) - CNT_W'(k);
      if ((CNT_W'(k) < len_eff) && (win_nxt[diff[WIN_W-1:0]] != pat_bytes[8*k +: 8])) begin
        all_eq = 1'b0;
      end
    end
  end

  assign bsm_inc   = (bsm_r < CNT_W'(MAX_PATTERN)) ? bsm_r + CNT_W'(1) : bsm_r;
  assign found     = (bsm_inc >= len_eff) && all_eq;
  assign start_pos = pos_r - POSITION_BITS'(len_eff - CNT_W'(1));
  assign pos_nxt   = req.end_of_text ? '0 : pos_r + POSITION_BITS'(1);

  always_comb begin
    if (req.end_of_text || found) begin
      bsm_nxt = '0;
    end else begin
      bsm_nxt = bsm_inc;
    end
  end

  always_comb begin
    res.match_found = found;
    res.match_start = found ? START_W'(start_pos) : '0;
    res.last_result = req.end_of_text;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        win_r[i] <= '0;
      end
      pos_r <= '0;
      bsm_r <= '0;
    end else if (push) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        win_r[i] <= req.end_of_text ? 8'h00 : win_nxt[i];
      end
      pos_r <= pos_nxt;
      bsm_r <= bsm_nxt;
    end
  end

  a_eot_clears_pos: assert property (@(posedge clk) disable iff (!rst_n)
    push && req.end_of_text |=> (pos_r == '0) && (bsm_r == '0))
    else $error("stream state not cleared after end of text");

  a_match_restarts_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    push && found |=> bsm_r == '0)
    else $error("spacing count not restarted after match");

  a_spacing_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bsm_r <= CNT_W'(MAX_PATTERN))
    else $error("spacing count above window depth");

endmodule

### hw/rtl/nps_skid.sv
// Two-entry result buffer: output register plus skid register.
`timescale 1ns / 1ps

module nps_skid (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  nps_pkg::out_res_t  push_res,
  output logic               push_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output nps_pkg::out_res_t  out_data
);

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              skid_valid_r;
  logic              skid_valid_nxt;
  nps_pkg::out_res_t out_data_r;
  nps_pkg::out_res_t out_data_nxt;
  nps_pkg::out_res_t skid_data_r;
  nps_pkg::out_res_t skid_data_nxt;
  logic              pop;

  // no request is taken while reset is held
  assign push_ready = rst_n && !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign pop        = out_valid_r && out_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_data_nxt  = push_res;
        out_valid_nxt = push;
      end
    end else if (push) begin
      skid_data_nxt  = push_res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held with empty output register");

endmodule

### hw/rtl/nonoverlapping_pattern_search_unit.sv
// The result of an accepted request is registered in the output or the skid register.
// Throughput: one request per cycle while in_ready is high; the window compare is a
// single combinational pass. in_ready drops only while the skid register is full.
// Reset (synchronous, rst_n low): window, position and spacing count cleared,
// pattern registers zero, pattern length 1, result buffer empty.
`timescale 1ns / 1ps

module nonoverlapping_pattern_search_unit #(
  parameter int MAX_PATTERN   = nps_pkg::MAX_PATTERN_DEF,
  parameter int POSITION_BITS = nps_pkg::POSITION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  nps_pkg::in_req_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output nps_pkg::out_res_t              out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [nps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nps_pkg::CFG_DATA_W-1:0] cfg_data
);

  nps_pkg::cfg_t     cfg;
  nps_pkg::out_res_t core_res;
  logic              push;

  assign push = in_valid && in_ready;

  nps_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  nps_match_core #(
    .MAX_PATTERN   (MAX_PATTERN),
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .req   (in_data),
    .cfg   (cfg),
    .res   (core_res)
  );

  nps_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_res   (core_res),
    .push_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

### tb/tb.sv
// Self-checking testbench for the non-overlapping pattern search unit.
`timescale 1ns / 1ps

module tb;

  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 7;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASES         = 6;
  localparam int PHASE_BYTES    = 84;
  localparam int MAX_LEN        = nps_pkg::MAX_PATTERN_DEF;
  localparam int NBYTES         = nps_pkg::PATTERN_BYTES;
  localparam int LEN_W          = nps_pkg::LEN_REG_W;
  localparam int DATA_W         = nps_pkg::CFG_DATA_W;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  nps_pkg::in_req_t                in_data = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  nps_pkg::out_res_t               out_data;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [nps_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [DATA_W-1:0]               cfg_data = '0;

  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned errors = 0;
  int unsigned quiet_cycles;

  // search state mirror
  logic [7:0]                     win_bytes [NBYTES];
  logic [nps_pkg::START_W-1:0]    next_pos;
  logic [LEN_W-1:0]               fresh_bytes;
  logic [DATA_W-1:0]              pat_low;
  logic [DATA_W-1:0]              pat_high;
  logic [LEN_W-1:0]               pat_len;

  nps_pkg::out_res_t expected_hits [$];

  nonoverlapping_pattern_search_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  function automatic void clear_text();
    for (int i = 0; i < NBYTES; i++) win_bytes[i] = 8'h00;
    next_pos    = '0;
    fresh_bytes = '0;
  endfunction

  function automatic nps_pkg::out_res_t search_step(nps_pkg::in_req_t req);
    nps_pkg::out_res_t res;
    int unsigned       n;
    bit                same;
    logic [127:0]      pat;
    pat = {pat_high, pat_low};
    n = 32'(pat_len);
    if (n == 0) n = 1;
    if (n > MAX_LEN) n = MAX_LEN;
    for (int i = NBYTES - 1; i > 0; i--) win_bytes[i] = win_bytes[i-1];
    win_bytes[0] = req.text_byte;
    if (fresh_bytes < LEN_W'(MAX_LEN)) fresh_bytes++;
    res = '0;
    if (32'(fresh_bytes) >= n) begin
      same = 1'b1;
      for (int k = 0; k < n; k++) begin
        if (win_bytes[n-1-k] != pat[8*k +: 8]) same = 1'b0;
      end
      if (same) begin
        res.match_found = 1'b1;
        res.match_start = next_pos - nps_pkg::START_W'(n - 1);
        fresh_bytes     = '0;
      end
    end
    next_pos++;
    res.last_result = req.end_of_text;
    if (req.end_of_text) clear_text();
    return res;
  endfunction

  always @(posedge clk) begin
    nps_pkg::out_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_hits.size() == 0) begin
        $error("result with no request pending: %p", out_data);
        errors++;
      end else begin
        want = expected_hits.pop_front();
        if (out_data.match_found !== want.match_found) begin
          $error("match_found: expected %0d, got %0d", want.match_found,
                 out_data.match_found);
          errors++;
        end
        if (out_data.match_start !== want.match_start) begin
          $error("match_start: expected %0d, got %0d", want.match_start,
                 out_data.match_start);
          errors++;
        end
        if (out_data.last_result !== want.last_result) begin
          $error("last_result: expected %0d, got %0d", want.last_result,
                 out_data.last_result);
          errors++;
        end
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_byte(logic [7:0] text_byte, logic eot);
    nps_pkg::in_req_t  req;
    nps_pkg::out_res_t exp_res;
    req.text_byte   = text_byte;
    req.end_of_text = eot;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    exp_res = search_step(req);
    expected_hits.insert(expected_hits.size(), exp_res);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_hits.size() != 0);
  endtask

  task automatic write_reg(nps_pkg::cfg_idx_t idx, logic [DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      nps_pkg::CFG_PATTERN_LOW:    pat_low  = value;
      nps_pkg::CFG_PATTERN_HIGH:   pat_high = value;
      nps_pkg::CFG_PATTERN_LENGTH: pat_len  = value[LEN_W-1:0];
      default: ;
    endcase
  endtask

  // only called with no request outstanding
  task automatic configure(logic [63:0] low_word, logic [63:0] high_word,
                           logic [63:0] len_word);
    write_reg(nps_pkg::CFG_PATTERN_LOW, low_word);
    write_reg(nps_pkg::CFG_PATTERN_HIGH, high_word);
    write_reg(nps_pkg::CFG_PATTERN_LENGTH, len_word);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // reset pattern: single zero byte
  task automatic test_reset_defaults();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_drained();
  endtask

  // length 0 acts as 1, length 31 as 16; full-length hit on the end-of-text byte
  task automatic test_length_limits();
    logic [63:0]  noise;
    logic [127:0] pat;
    noise = {$urandom, $urandom};
    configure({noise[63:8], 8'hA5}, {$urandom, $urandom}, 64'd0);
    send_byte(8'hA5, 1'b0);
    wait_drained();
    pat = {64'h80FF_7F01_00FE_3CC3, 64'hFF00_55AA_0102_8040};
    configure(pat[63:0], pat[127:64], 64'd31);
    for (int k = 0; k < NBYTES; k++)
      send_byte(pat[8*k +: 8], k == NBYTES - 1);
    wait_drained();
  endtask

  // "aa" over "aaaaa": hits at 2nd and 4th byte only; unused bytes are noise
  task automatic test_non_overlap();
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    configure({noise[63:16], 16'h6161}, {$urandom, $urandom}, 64'd2);
    for (int k = 0; k < 5; k++) send_byte(8'h61, k == 4);
    wait_drained();
  endtask

  task automatic test_random_text();
    int unsigned idle_pct [3];
    int unsigned stall_pct [3];
    logic [7:0]  pat [NBYTES];
    logic [7:0]  pending [$];
    logic [63:0] low_word;
    logic [63:0] high_word;
    logic [63:0] len_word;
    logic [7:0]  sym_a;
    logic [7:0]  sym_b;
    bit          two_symbol;
    int unsigned len;
    int unsigned n;
    int unsigned r;
    int unsigned sent;
    idle_pct  = '{18, 61, 0};
    stall_pct = '{61, 18, 0};
    for (int mode = 0; mode < 3; mode++) begin
      sender_idle_pct    = idle_pct[mode];
      receiver_stall_pct = stall_pct[mode];
      for (int phase = 0; phase < PHASES; phase++) begin
        sym_a      = 8'($urandom_range(255));
        sym_b      = 8'($urandom_range(255));
        two_symbol = ($urandom_range(1) == 1);
        for (int k = 0; k < NBYTES; k++) begin
          if (two_symbol) pat[k] = $urandom_range(1) ? sym_a : sym_b;
          else pat[k] = 8'($urandom_range(255));
        end
        for (int k = 0; k < 8; k++) begin
          low_word[8*k +: 8]  = pat[k];
          high_word[8*k +: 8] = pat[k+8];
        end
        r = $urandom_range(99);
        if (phase == 0) len = 1;
        else if (phase == 1) len = MAX_LEN;
        else if (phase == 2) len = (r < 50) ? 0 : $urandom_range(31, MAX_LEN + 1);
        else if (r < 45) len = $urandom_range(4, 1);
        else if (r < 75) len = $urandom_range(15, 5);
        else if (r < 88) len = MAX_LEN;
        else if (r < 94) len = 0;
        else len = $urandom_range(31, MAX_LEN + 1);
        len_word = {$urandom, $urandom};
        len_word[LEN_W-1:0] = LEN_W'(len);
        n = (len == 0) ? 1 : ((len > MAX_LEN) ? MAX_LEN : len);
        configure(low_word, high_word, len_word);
        pending.delete();
        sent = 0;
        while (sent < PHASE_BYTES) begin
          if (pending.size() == 0) begin
            r = $urandom_range(99);
            if (r < 55) begin
              for (int k = 0; k < n; k++) pending.insert(pending.size(), pat[k]);
              // corrupted copy
              if (r >= 40) begin
                r = $urandom_range(n - 1);
                pending[r] = pending[r] ^ 8'($urandom_range(255, 1));
              end
            end else if (r < 80) begin
              pending.insert(pending.size(),
                             two_symbol ? ($urandom_range(1) ? sym_a : sym_b)
                                        : pat[$urandom_range(n - 1)]);
            end else begin
              pending.insert(pending.size(), 8'($urandom_range(255)));
            end
          end
          send_byte(pending.pop_front(), $urandom_range(99) < 3);
          sent++;
        end
        wait_drained();
      end
    end
  endtask

  initial begin
    pat_low            = '0;
    pat_high           = '0;
    pat_len            = LEN_W'(1);
    sender_idle_pct    = 18;
    receiver_stall_pct = 61;
    clear_text();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_length_limits();
    test_non_overlap();
    test_random_text();
    wait_drained();
    repeat (20) @(posedge clk);
    if (expected_hits.size() != 0) begin
      $error("%0d results never arrived", expected_hits.size());
      errors++;
    end
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
